>>> hw/rtl/bss_pkg.sv
// Shared types and constants for the bitmap scan statistics block.
`timescale 1ns / 1ps

package bss_pkg;

   localparam int MAX_MAP_BYTES = 4096;
   localparam int POS_W         = (MAX_MAP_BYTES > 1) ? $clog2(MAX_MAP_BYTES) : 1;
   localparam int BYTE_W        = 8;
   localparam int BIT_SEL_W     = 3;
   localparam int ONES_W        = 4;
   localparam int COUNT_W       = 16;
   localparam int INDEX_W       = 15;

   localparam logic [BYTE_W-1:0]  ALL_ONES_BYTE  = 8'hFF;
   localparam logic [COUNT_W-1:0] MAP_BITS_RESET = 16'd32768;

   typedef struct packed {
      logic [BYTE_W-1:0] map_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] set_count;
      logic [COUNT_W-1:0] clear_count;
      logic               set_found;
      logic [INDEX_W-1:0] first_set_index;
      logic               clear_found;
      logic [INDEX_W-1:0] first_clear_index;
      logic               all_set;
      logic               all_clear;
   } rsp_type;

   typedef struct packed {
      logic [ONES_W-1:0]    ones;
      logic                 any_one;
      logic                 any_zero;
      logic [BIT_SEL_W-1:0] one_pos;
      logic [BIT_SEL_W-1:0] zero_pos;
   } byte_stats_type;

endpackage

>>> hw/rtl/bitmap_scan_statistics_top.sv
// Top level of the bitmap scan statistics block.
// A result passes the input register and then the result register before it is valid.
// Throughput: one byte per cycle; only a last byte waits, while a held result lacks rsp_ready.
// The input register feeds the scan logic; the result register parts the output side.
// Reset (synchronous) clears the scan state and sets map_bits to 32768.
`timescale 1ns / 1ps

module bitmap_scan_statistics_top import bss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   logic               s1_valid_ff, s1_valid_in;
   req_type            s1_data_ff, s1_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0] map_bits_ff, map_bits_in;

   logic               rsp_free;
   logic               s1_go;
   logic               req_take;
   byte_stats_type     stats;
   rsp_type            result;

   bss_byte_scan u_scan (
      .map_byte (s1_data_ff.map_byte),
      .stats    (stats)
   );

   bss_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_go),
      .last_byte (s1_data_ff.last_byte),
      .stats     (stats),
      .map_bits  (map_bits_ff),
      .result    (result)
   );

   always_comb begin
      rsp_free  = !rsp_valid_ff || rsp_ready;
      s1_go     = s1_valid_ff && (!s1_data_ff.last_byte || rsp_free);
      req_ready = !s1_valid_ff || s1_go;
      req_take  = req_valid && req_ready;

      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_go && s1_data_ff.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      map_bits_in = csr_wr_en ? csr_wr_data : map_bits_ff;

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         map_bits_ff  <= MAP_BITS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         map_bits_ff  <= map_bits_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_go && s1_data_ff.last_byte))
      else $error("result raised without a last byte");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(s1_go && s1_data_ff.last_byte))
      else $error("pending result overwritten");

endmodule

>>> hw/rtl/bss_byte_scan.sv
// Per-byte popcount and lowest set / lowest clear bit encoders.
`timescale 1ns / 1ps

module bss_byte_scan import bss_pkg::*; (
   input  logic [BYTE_W-1:0] map_byte,
   output byte_stats_type    stats
);

   logic [BYTE_W-1:0] inv_byte;

   always_comb begin
      inv_byte       = ~map_byte;
      stats.ones     = '0;
      stats.one_pos  = '0;
      stats.zero_pos = '0;
      stats.any_one  = (map_byte != '0);
      stats.any_zero = (map_byte != ALL_ONES_BYTE);
      for (int i = 0; i < BYTE_W; i++) begin
         stats.ones = stats.ones + ONES_W'(map_byte[i]);
      end
      // scan from the top so the lowest hit wins
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         if (map_byte[i]) begin
            stats.one_pos = BIT_SEL_W'(i);
         end
         if (inv_byte[i]) begin
            stats.zero_pos = BIT_SEL_W'(i);
         end
      end
   end

endmodule

>>> hw/rtl/bss_accum.sv
// Running scan state and summary result builder.
`timescale 1ns / 1ps

module bss_accum import bss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               last_byte,
   input  byte_stats_type     stats,
   input  logic [COUNT_W-1:0] map_bits,
   output rsp_type            result
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [COUNT_W-1:0] ones_ff, ones_in;
   logic               one_seen_ff, one_seen_in;
   logic [INDEX_W-1:0] one_at_ff, one_at_in;
   logic               zero_seen_ff, zero_seen_in;
   logic [INDEX_W-1:0] zero_at_ff, zero_at_in;

   logic [INDEX_W-1:0] base;
   logic [COUNT_W:0]   ones_sum;
   logic [COUNT_W-1:0] ones_upd;
   logic               one_seen_upd, zero_seen_upd;
   logic [INDEX_W-1:0] one_at_upd, zero_at_upd;
   logic [POS_W-1:0]   pos_upd;

   always_comb begin
      base      = INDEX_W'({pos_ff, 3'b000});
      ones_sum  = {1'b0, ones_ff} + (COUNT_W+1)'(stats.ones);
      ones_upd  = ones_sum[COUNT_W] ? '1 : ones_sum[COUNT_W-1:0];

      one_seen_upd  = one_seen_ff | stats.any_one;
      one_at_upd    = (!one_seen_ff && stats.any_one)
                      ? base + INDEX_W'(stats.one_pos) : one_at_ff;
      zero_seen_upd = zero_seen_ff | stats.any_zero;
      zero_at_upd   = (!zero_seen_ff && stats.any_zero)
                      ? base + INDEX_W'(stats.zero_pos) : zero_at_ff;
      pos_upd       = (pos_ff == POS_W'(MAX_MAP_BYTES - 1)) ? '0 : pos_ff + 1'b1;

      result.set_count         = ones_upd;
      result.clear_count       = (map_bits > ones_upd) ? map_bits - ones_upd : '0;
      result.set_found         = one_seen_upd;
      result.first_set_index   = one_seen_upd ? one_at_upd : '0;
      result.clear_found       = zero_seen_upd;
      result.first_clear_index = zero_seen_upd ? zero_at_upd : '0;
      result.all_set           = !zero_seen_upd;
      result.all_clear         = !one_seen_upd;

      pos_in       = pos_ff;
      ones_in      = ones_ff;
      one_seen_in  = one_seen_ff;
      one_at_in    = one_at_ff;
      zero_seen_in = zero_seen_ff;
      zero_at_in   = zero_at_ff;
      if (step) begin
         if (last_byte) begin
            pos_in       = '0;
            ones_in      = '0;
            one_seen_in  = 1'b0;
            one_at_in    = '0;
            zero_seen_in = 1'b0;
            zero_at_in   = '0;
         end else begin
            pos_in       = pos_upd;
            ones_in      = ones_upd;
            one_seen_in  = one_seen_upd;
            one_at_in    = one_at_upd;
            zero_seen_in = zero_seen_upd;
            zero_at_in   = zero_at_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ones_ff      <= '0;
         one_seen_ff  <= 1'b0;
         one_at_ff    <= '0;
         zero_seen_ff <= 1'b0;
         zero_at_ff   <= '0;
      end else begin
         pos_ff       <= pos_in;
         ones_ff      <= ones_in;
         one_seen_ff  <= one_seen_in;
         one_at_ff    <= one_at_in;
         zero_seen_ff <= zero_seen_in;
         zero_at_ff   <= zero_at_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && last_byte |=> pos_ff == '0 && ones_ff == '0 && !one_seen_ff && !zero_seen_ff)
      else $error("scan state not cleared after last byte");

   a_one_at_idle: assert property (@(posedge clock) disable iff (reset)
      !one_seen_ff |-> one_at_ff == '0)
      else $error("first one index set without a one seen");

   a_zero_at_idle: assert property (@(posedge clock) disable iff (reset)
      !zero_seen_ff |-> zero_at_ff == '0)
      else $error("first zero index set without a zero seen");

   a_one_at_sticky: assert property (@(posedge clock) disable iff (reset)
      one_seen_ff && !(step && last_byte) |=> one_at_ff == $past(one_at_ff))
      else $error("recorded first one index replaced");

endmodule
